FILE: rtl/task_router_and_steal_victim_select_defines.svh
// Assertion macros shared by the RTL files.
`ifndef TASK_ROUTER_AND_STEAL_VICTIM_SELECT_DEFINES_SVH
`define TASK_ROUTER_AND_STEAL_VICTIM_SELECT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TRSVS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TRSVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/trsvs_pkg.sv
package trsvs_pkg;

    localparam int ID_W   = 5;
    localparam int NW_W   = 6;
    localparam int KEY_W  = 64;
    localparam int MASK_W = 32;
    localparam int BITS_W = 7;
    localparam int TERM_W = 3;

    localparam int DEF_MAX_WORKERS = 32;
    localparam int HARD_CAP        = 32;

    localparam logic [KEY_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;

    // FNV prime = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0
    localparam logic [TERM_W-1:0] NUM_TERMS = 3'd7;

    function automatic logic [5:0] term_shift(input logic [TERM_W-1:0] k);
        logic [5:0] s;
        unique case (k)
            3'd0:    s = 6'd0;
            3'd1:    s = 6'd1;
            3'd2:    s = 6'd4;
            3'd3:    s = 6'd5;
            3'd4:    s = 6'd7;
            3'd5:    s = 6'd8;
            3'd6:    s = 6'd40;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

FILE: rtl/task_router_and_steal_victim_select.sv
// From accept to m_valid: a map answered without hashing or a steal with no I/O workers goes
//   straight to the output; a hashed map runs the FNV shift-add terms, the serial remainder, output.
// A steal runs the serial remainder for the victim pointer, scans the candidates in turn, outputs.
// One transaction in flight; s_ready returns in the same cycle as m_valid rises; a finished
//   result waits in S_DONE while an earlier one is held by m_ready stalls.
// Reset: synchronous active-low aresetn; num_workers returns to 1, victim pointer to 0.
`include "task_router_and_steal_victim_select_defines.svh"

module task_router_and_steal_victim_select
    import trsvs_pkg::*;
#(
    parameter int MAX_WORKERS = DEF_MAX_WORKERS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [NW_W-1:0]   cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic              s_task_valid,
    input  logic              s_submitter_valid,
    input  logic [ID_W-1:0]   s_submitter_id,
    input  logic [KEY_W-1:0]  s_hash_key,
    input  logic [ID_W-1:0]   s_idle_id,
    input  logic [MASK_W-1:0] s_nonempty_mask,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ID_W-1:0]   m_dest_worker,
    output logic              m_steal_found
);

    localparam int CAP = (MAX_WORKERS < HARD_CAP) ? MAX_WORKERS : HARD_CAP;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HASH = 5'b00010,
        S_MOD  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [NW_W-1:0]   num_workers_reg;
    logic [ID_W-1:0]   victim_pointer_reg, victim_pointer_next;
    logic              steal_reg, steal_next;
    logic [KEY_W-1:0]  x_reg, x_next;
    logic [KEY_W-1:0]  acc_reg, acc_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [ID_W-1:0]   idle_reg, idle_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [ID_W-1:0]   idx_reg, idx_next;
    logic [ID_W-1:0]   steps_reg, steps_next;
    logic [ID_W-1:0]   res_dest_reg, res_dest_next;
    logic              res_found_reg, res_found_next;
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_dest_reg, m_dest_next;
    logic              m_found_reg, m_found_next;

    logic [NW_W-1:0]   n_sat32;
    logic [NW_W-1:0]   n_eff;
    logic [ID_W-1:0]   count;
    logic              accept;
    logic              out_free;
    logic              sub_local;
    logic [ID_W-1:0]   cand_id;
    logic              cand_hit;
    logic [ID_W-1:0]   idx_inc;

    logic              mod_start;
    logic [KEY_W-1:0]  mod_dividend;
    logic [BITS_W-1:0] mod_nbits;
    mod_stat_t         mod_stat;
    logic [ID_W-1:0]   mod_rem;

    assign n_sat32  = (num_workers_reg > NW_W'(HARD_CAP)) ? NW_W'(HARD_CAP) : num_workers_reg;
    assign n_eff    = (n_sat32 > NW_W'(CAP)) ? NW_W'(CAP) : n_sat32;
    assign count    = (n_eff > NW_W'(2)) ? ID_W'(n_eff - NW_W'(2)) : '0;
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign sub_local = s_submitter_valid && (s_submitter_id != '0) && (s_submitter_id <= count);
    assign cand_id  = idx_reg + 1'b1;
    assign cand_hit = (cand_id != idle_reg) && mask_reg[cand_id];
    assign idx_inc  = (cand_id == count) ? '0 : cand_id;

    always_comb begin
        state_next          = state_reg;
        victim_pointer_next = victim_pointer_reg;
        steal_next          = steal_reg;
        x_next              = x_reg;
        acc_next            = acc_reg;
        term_next           = term_reg;
        idle_next           = idle_reg;
        mask_next           = mask_reg;
        idx_next            = idx_reg;
        steps_next          = steps_reg;
        res_dest_next       = res_dest_reg;
        res_found_next      = res_found_reg;
        m_valid_next        = m_valid_reg;
        m_dest_next         = m_dest_reg;
        m_found_next        = m_found_reg;
        mod_start           = 1'b0;
        mod_dividend        = {victim_pointer_reg, {(KEY_W-ID_W){1'b0}}};
        mod_nbits           = BITS_W'(ID_W);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    steal_next     = s_cmd;
                    idle_next      = s_idle_id;
                    mask_next      = s_nonempty_mask;
                    x_next         = FNV_BASIS ^ s_hash_key;
                    acc_next       = '0;
                    term_next      = '0;
                    res_dest_next  = '0;
                    res_found_next = 1'b0;
                    if (s_cmd) begin
                        if (count == '0) begin
                            state_next = S_DONE;
                        end else begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                    end else if (!s_task_valid) begin
                        state_next = S_DONE;
                    end else if (sub_local) begin
                        res_dest_next = s_submitter_id;
                        state_next    = S_DONE;
                    end else if (count == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                acc_next  = acc_reg + (x_reg << term_shift(term_reg));
                term_next = term_reg + 1'b1;
                if (term_reg == NUM_TERMS - 1'b1) begin
                    mod_start    = 1'b1;
                    mod_dividend = acc_next;
                    mod_nbits    = BITS_W'(KEY_W);
                    state_next   = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_stat.done) begin
                    if (steal_reg) begin
                        idx_next   = mod_rem;
                        steps_next = count;
                        state_next = S_SCAN;
                    end else begin
                        res_dest_next = mod_rem + 1'b1;
                        state_next    = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (cand_hit) begin
                    res_dest_next       = cand_id;
                    res_found_next      = 1'b1;
                    victim_pointer_next = idx_inc;
                    state_next          = S_DONE;
                end else begin
                    idx_next   = idx_inc;
                    steps_next = steps_reg - 1'b1;
                    if (steps_reg == ID_W'(1)) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_dest_next  = res_dest_reg;
                    m_found_next = res_found_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            num_workers_reg    <= NW_W'(1);
            victim_pointer_reg <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            victim_pointer_reg <= victim_pointer_next;
            m_valid_reg        <= m_valid_next;
            if (cfg_we) begin
                num_workers_reg <= cfg_wdata;
            end
        end
        steal_reg     <= steal_next;
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        term_reg      <= term_next;
        idle_reg      <= idle_next;
        mask_reg      <= mask_next;
        idx_reg       <= idx_next;
        steps_reg     <= steps_next;
        res_dest_reg  <= res_dest_next;
        res_found_reg <= res_found_next;
        m_dest_reg    <= m_dest_next;
        m_found_reg   <= m_found_next;
    end

    trsvs_mod_serial u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .nbits     (mod_nbits),
        .divisor   (count),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    assign m_valid       = m_valid_reg;
    assign m_dest_worker = m_dest_reg;
    assign m_steal_found = m_found_reg;

    `TRSVS_ASSERT_SAME(a_ptr_range, aclk, aresetn, 1'b1, victim_pointer_reg < ID_W'(30))
    `TRSVS_ASSERT_SAME(a_found_range, aclk, aresetn, m_valid_reg && m_found_reg,
        (m_dest_reg != '0) && (m_dest_reg <= ID_W'(30)))
    `TRSVS_ASSERT_SAME(a_scan_count, aclk, aresetn, state_reg == S_SCAN, count != '0)
    `TRSVS_ASSERT_SAME(a_mod_done_state, aclk, aresetn, mod_stat.done, state_reg == S_MOD)

endmodule

FILE: rtl/trsvs_mod_serial.sv
`include "task_router_and_steal_victim_select_defines.svh"

module trsvs_mod_serial
    import trsvs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [KEY_W-1:0]  dividend,
    input  logic [BITS_W-1:0] nbits,
    input  logic [ID_W-1:0]   divisor,
    output mod_stat_t         stat,
    output logic [ID_W-1:0]   remainder
);

    logic [KEY_W-1:0]  shift_reg, shift_next;
    logic [BITS_W-1:0] left_reg, left_next;
    logic [ID_W-1:0]   rem_reg, rem_next;
    logic [ID_W-1:0]   div_reg, div_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ID_W:0]     trial;

    always_comb begin
        shift_next = shift_reg;
        left_next  = left_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, shift_reg[KEY_W-1]};
        if (start) begin
            shift_next = dividend;
            left_next  = nbits;
            rem_next   = '0;
            div_next   = divisor;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = ID_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[ID_W-1:0];
            end
            shift_next = {shift_reg[KEY_W-2:0], 1'b0};
            left_next  = left_reg - 1'b1;
            if (left_reg == BITS_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        shift_reg <= shift_next;
        left_reg  <= left_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

    `TRSVS_ASSERT_SAME(a_rem_below_div, aclk, aresetn, busy_reg, rem_reg < div_reg)
    `TRSVS_ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg)
    `TRSVS_ASSERT_SAME(a_done_not_busy, aclk, aresetn, done_reg, !busy_reg)

endmodule

FILE: verif/tb_task_router_and_steal_victim_select.sv
module tb_task_router_and_steal_victim_select;
    import trsvs_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int WORKER_CAP = 32;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 65;
    localparam int HOLD_AT_RESULT = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int EAGER_RCV_FROM = 400;
    localparam int EAGER_RCV_TO = 470;
    localparam int TAIL_CYCLES = 80;
    localparam logic [KEY_W-1:0] FNV_OFFSET = 64'hCBF29CE484222325;
    localparam logic [KEY_W-1:0] FNV_MULT = 64'd1099511628211;

    typedef enum logic {
        CMD_MAP   = 1'b0,
        CMD_STEAL = 1'b1
    } route_cmd_t;

    typedef struct {
        route_cmd_t         cmd;
        logic               task_valid;
        logic               sub_valid;
        logic [ID_W-1:0]    sub_id;
        logic [KEY_W-1:0]   key;
        logic [ID_W-1:0]    idle_id;
        logic [MASK_W-1:0]  mask;
        int unsigned        gap;
    } route_req_t;

    typedef struct packed {
        logic [ID_W-1:0] dest;
        logic            found;
    } route_result_t;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [NW_W-1:0]   cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_cmd = 1'b0;
    logic              s_task_valid = 1'b0;
    logic              s_submitter_valid = 1'b0;
    logic [ID_W-1:0]   s_submitter_id = '0;
    logic [KEY_W-1:0]  s_hash_key = '0;
    logic [ID_W-1:0]   s_idle_id = '0;
    logic [MASK_W-1:0] s_nonempty_mask = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ID_W-1:0]   m_dest_worker;
    logic              m_steal_found;

    logic [NW_W-1:0]   workers_cfg = 6'd1;
    logic [ID_W-1:0]   victim_ptr = '0;

    route_req_t        pending_q[$];
    route_result_t     dest_expect_q[$];
    route_req_t        cur_req;
    int                send_gap = -1;
    int unsigned       queued_cnt = 0;
    int unsigned       accepted_cnt = 0;
    int unsigned       results_seen = 0;
    int unsigned       rcv_wait = 0;
    int unsigned       hold_left = 0;
    int unsigned       err_cnt = 0;
    int unsigned       cycle_cnt = 0;

    task_router_and_steal_victim_select dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_task_valid      (s_task_valid),
        .s_submitter_valid (s_submitter_valid),
        .s_submitter_id    (s_submitter_id),
        .s_hash_key        (s_hash_key),
        .s_idle_id         (s_idle_id),
        .s_nonempty_mask   (s_nonempty_mask),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_dest_worker     (m_dest_worker),
        .m_steal_found     (m_steal_found)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned io_workers();
        int unsigned n;
        n = workers_cfg;
        if (n > WORKER_CAP) n = WORKER_CAP;
        return (n > 2) ? n - 2 : 0;
    endfunction

    function automatic route_result_t predict_dest(input route_req_t r);
        route_result_t    res;
        logic [KEY_W-1:0] h;
        int unsigned      cnt;
        int unsigned      start;
        int unsigned      idx;
        res.dest = '0;
        res.found = 1'b0;
        cnt = io_workers();
        if (r.cmd == CMD_MAP) begin
            if (!r.task_valid) begin
                res.dest = '0;
            end else if (r.sub_valid && r.sub_id >= 1 && r.sub_id <= cnt) begin
                res.dest = r.sub_id;
            end else if (cnt != 0) begin
                h = (FNV_OFFSET ^ r.key) * FNV_MULT;
                res.dest = ID_W'(64'd1 + h % cnt);
            end
        end else if (cnt != 0) begin
            start = victim_ptr % cnt;
            for (int a = 0; a < cnt && !res.found; a++) begin
                idx = (start + a) % cnt;
                if (idx + 1 != r.idle_id && r.mask[idx + 1]) begin
                    res.dest = ID_W'(idx + 1);
                    res.found = 1'b1;
                    victim_ptr = ID_W'((idx + 1) % cnt);
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_cnt < 200) $display("MISMATCH: %s", msg);
        err_cnt++;
    endtask

    task automatic enqueue(input route_req_t r);
        pending_q = {pending_q, r};
        queued_cnt++;
    endtask

    function automatic route_req_t noise_req();
        route_req_t r;
        r.cmd = route_cmd_t'($urandom_range(0, 1));
        r.task_valid = 1'($urandom_range(0, 1));
        r.sub_valid = 1'($urandom_range(0, 1));
        r.sub_id = ID_W'($urandom_range(0, 31));
        r.key = {$urandom, $urandom};
        r.idle_id = ID_W'($urandom_range(0, 31));
        r.mask = $urandom;
        r.gap = $urandom_range(0, 10);
        return r;
    endfunction

    task automatic push_map(input logic tv, input logic sv, input logic [ID_W-1:0] sid,
                            input logic [KEY_W-1:0] key);
        route_req_t r;
        r = noise_req();
        r.cmd = CMD_MAP;
        r.task_valid = tv;
        r.sub_valid = sv;
        r.sub_id = sid;
        r.key = key;
        enqueue(r);
    endtask

    task automatic push_steal(input logic [ID_W-1:0] idle, input logic [MASK_W-1:0] mask);
        route_req_t r;
        r = noise_req();
        r.cmd = CMD_STEAL;
        r.idle_id = idle;
        r.mask = mask;
        enqueue(r);
    endtask

    task automatic push_random(input bit eager);
        route_req_t  r;
        int unsigned cnt;
        cnt = io_workers();
        r = noise_req();
        r.task_valid = ($urandom_range(0, 4) != 0);
        if (cnt != 0 && $urandom_range(0, 1)) r.sub_id = ID_W'($urandom_range(1, cnt));
        if (cnt != 0 && $urandom_range(0, 2) != 0) r.idle_id = ID_W'($urandom_range(1, cnt));
        case ($urandom_range(0, 4))
            0: r.mask = '0;
            1: r.mask = 32'h1 << $urandom_range(0, 31);
            2: r.mask = $urandom & $urandom & $urandom;
            3: r.mask = '1;
            default: r.mask = $urandom;
        endcase
        if (eager || $urandom_range(0, 3) == 0) r.gap = 0;
        enqueue(r);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (accepted_cnt != queued_cnt || dest_expect_q.size() != 0);
    endtask

    task automatic set_workers(input logic [NW_W-1:0] n);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= n;
        workers_cfg = n;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = -1;
        end else begin
            if (s_valid && s_ready) begin
                dest_expect_q = {dest_expect_q, predict_dest(cur_req)};
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && send_gap < 0) send_gap = pending_q[0].gap;
                if (pending_q.size() != 0 && send_gap == 0) begin
                    cur_req = pending_q.pop_front();
                    send_gap = -1;
                    s_valid <= 1'b1;
                    s_cmd <= cur_req.cmd;
                    s_task_valid <= cur_req.task_valid;
                    s_submitter_valid <= cur_req.sub_valid;
                    s_submitter_id <= cur_req.sub_id;
                    s_hash_key <= cur_req.key;
                    s_idle_id <= cur_req.idle_id;
                    s_nonempty_mask <= cur_req.mask;
                end else begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        route_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rcv_wait = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (dest_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction dest_worker %0d found %0d",
                                              m_dest_worker, m_steal_found));
                end else begin
                    want = dest_expect_q.pop_front();
                    if (m_dest_worker !== want.dest)
                        report_mismatch($sformatf("transaction %0d dest_worker %0d expected %0d",
                                                  results_seen, m_dest_worker, want.dest));
                    if (m_steal_found !== want.found)
                        report_mismatch($sformatf("transaction %0d steal_found %0d expected %0d",
                                                  results_seen, m_steal_found, want.found));
                end
                results_seen++;
                // hold off long enough to back up the input
                if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
                if (results_seen >= EAGER_RCV_FROM && results_seen < EAGER_RCV_TO)
                    rcv_wait = 0;
                else
                    rcv_wait = $urandom_range(0, 10);
            end else if (m_valid && rcv_wait > 0) begin
                rcv_wait--;
            end
            if (hold_left > 0) hold_left--;
            m_ready <= (rcv_wait == 0) && (hold_left == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [NW_W-1:0] phase_cfg [RANDOM_PHASES];
        phase_cfg = '{6'd3, 6'd32, 6'd63, 6'd12, 6'd4, 6'd0, 6'd30, 6'd2, 6'd33, 6'd17};
        phase_cfg[5] = NW_W'($urandom_range(0, 63));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset count of one: no I/O workers
        push_map(1'b0, 1'b0, 5'd0, '0);
        push_map(1'b1, 1'b1, 5'd1, {$urandom, $urandom});
        push_steal(5'd0, '1);

        set_workers(6'd0);
        push_map(1'b1, 1'b1, 5'd1, '1);
        push_steal(5'd1, '1);

        set_workers(6'd2);
        push_map(1'b1, 1'b0, 5'd0, {$urandom, $urandom});
        push_steal(5'd0, '1);

        set_workers(6'd8);
        push_map(1'b0, 1'b1, 5'd3, '1);
        push_map(1'b1, 1'b1, 5'd1, {$urandom, $urandom});
        push_map(1'b1, 1'b1, 5'd6, {$urandom, $urandom});
        push_map(1'b1, 1'b1, 5'd7, {$urandom, $urandom});
        push_map(1'b1, 1'b1, 5'd0, {$urandom, $urandom});
        push_map(1'b1, 1'b0, 5'd3, '0);
        push_map(1'b1, 1'b0, 5'd31, '1);
        push_map(1'b1, 1'b0, 5'd0, FNV_OFFSET);
        push_steal(5'd1, '1);
        push_steal(5'd0, '0);
        push_steal(5'd31, 32'h8000_0081);
        push_steal(5'd5, 32'h0000_0020);
        push_steal(5'd0, 32'h0000_0060);

        // leave the pointer out of range for the smaller count
        set_workers(6'd4);
        push_steal(5'd0, '1);
        push_steal(5'd2, '1);

        set_workers(6'd63);
        push_map(1'b1, 1'b1, 5'd30, {$urandom, $urandom});
        push_map(1'b1, 1'b1, 5'd31, {$urandom, $urandom});
        push_steal(5'd30, 32'h4000_0000);
        push_steal(5'd0, '1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_workers(phase_cfg[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) push_random(p == 6 || p == 8);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (dest_expect_q.size() != 0)
            report_mismatch($sformatf("%0d transactions never arrived", dest_expect_q.size()));
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
